[rtl/tpo_pkg.sv]
// Shared constants for the triangle pair overlap pipeline.
`default_nettype none
package tpo_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int VERT_BITS      = 48;
  localparam int PIPE_LATENCY   = 6;
endpackage
`default_nettype wire

[rtl/triangle_pair_overlap_sat.sv]
// Top level: triangle pair overlap by separating axis test over 17 axes.
//
// Usage: drive the six packed vertices (x, y, z signed, COORD_BITS each)
// and raise start for one cycle per transaction. busy is always low, so a
// new pair is taken on every clock edge at which start is high.
// When an accepted transaction leaves the last register stage, done is high for one
// cycle and overlap holds the answer: 1 when no axis separates the two
// triangles, 0 when they are disjoint. Touching counts as overlap.
// Throughput is one pair per cycle through six register stages: edges,
// face and edge cross products, in-plane normals, partial products,
// projection sums, interval test. Latency is set by the wide multiplies,
// split into low and high partial products over two stages.
// Reset clears the stage valid bits; pairs in flight are dropped.
// The receiver cannot stall; every result is shown exactly once.
`default_nettype none
module triangle_pair_overlap_sat #(
  parameter int COORD_BITS = tpo_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tpo_pkg::VERT_BITS-1:0] tri_a_v0,
  input  wire logic [tpo_pkg::VERT_BITS-1:0] tri_a_v1,
  input  wire logic [tpo_pkg::VERT_BITS-1:0] tri_a_v2,
  input  wire logic [tpo_pkg::VERT_BITS-1:0] tri_b_v0,
  input  wire logic [tpo_pkg::VERT_BITS-1:0] tri_b_v1,
  input  wire logic [tpo_pkg::VERT_BITS-1:0] tri_b_v2,
  output logic                               done,
  output logic                               overlap
);
  import tpo_pkg::*;
  localparam int C = COORD_BITS;

  logic [VERT_BITS-1:0]   raw [6];
  logic                   v1, v3, v5;
  logic signed [C:0]      tv1 [5][3];
  logic signed [C:0]      e1 [3][3];
  logic signed [C:0]      f1 [3][3];
  logic signed [C:0]      tv3 [5][3];
  logic signed [3*C+5:0]  ax [17][3];
  logic signed [4*C+8:0]  proj [17][5];

  assign busy = 1'b0;
  assign raw[0] = tri_a_v0;
  assign raw[1] = tri_a_v1;
  assign raw[2] = tri_a_v2;
  assign raw[3] = tri_b_v0;
  assign raw[4] = tri_b_v1;
  assign raw[5] = tri_b_v2;

  tpo_edges #(.COORD_BITS(C)) u_edges (
    .clk(clk), .rst(rst), .in_vld(start & ~busy), .raw(raw),
    .vld(v1), .tv(tv1), .e(e1), .f(f1)
  );

  tpo_axes #(.COORD_BITS(C)) u_axes (
    .clk(clk), .rst(rst), .in_vld(v1), .tv_in(tv1), .e(e1), .f(f1),
    .vld(v3), .tv(tv3), .ax(ax)
  );

  tpo_project #(.COORD_BITS(C)) u_project (
    .clk(clk), .rst(rst), .in_vld(v3), .tv(tv3), .ax(ax),
    .vld(v5), .proj(proj)
  );

  tpo_decide #(.COORD_BITS(C)) u_decide (
    .clk(clk), .rst(rst), .in_vld(v5), .proj(proj),
    .vld(done), .overlap(overlap)
  );

  a_start_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##PIPE_LATENCY done) else $error("accepted pair produced no result");
  a_done_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, PIPE_LATENCY)) else $error("result without a pair");
  a_reset_flush: assert property (@(posedge clk)
    $fell(rst) |-> !done) else $error("result right after reset");
endmodule
`default_nettype wire

[rtl/tpo_edges.sv]
// Stage 1: unpack vertices, translate to A vertex 0, form triangle edges.
`default_nettype none
module tpo_edges #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_vld,
  input  wire logic [tpo_pkg::VERT_BITS-1:0] raw [6],
  output logic                               vld,
  output logic signed [COORD_BITS:0]         tv [5][3],
  output logic signed [COORD_BITS:0]         e [3][3],
  output logic signed [COORD_BITS:0]         f [3][3]
);
  import tpo_pkg::*;
  localparam int C  = COORD_BITS;
  localparam int PW = 3 * C;

  logic [PW-1:0]           ext [6];
  logic signed [C-1:0]     crd [6][3];
  logic signed [C:0]       tv_next [5][3];
  logic signed [C:0]       e_next [3][3];
  logic signed [C:0]       f_next [3][3];

  always_comb begin
    for (int v = 0; v < 6; v++) begin
      ext[v] = PW'({{PW{1'b0}}, raw[v]});
      for (int k = 0; k < 3; k++) crd[v][k] = signed'(ext[v][k*C +: C]);
    end
    for (int k = 0; k < 3; k++) begin
      tv_next[0][k] = (C+1)'(crd[1][k]) - (C+1)'(crd[0][k]);
      tv_next[1][k] = (C+1)'(crd[2][k]) - (C+1)'(crd[0][k]);
      for (int j = 0; j < 3; j++)
        tv_next[2+j][k] = (C+1)'(crd[3+j][k]) - (C+1)'(crd[0][k]);
      for (int i = 0; i < 3; i++) begin
        e_next[i][k] = (C+1)'(crd[(i+1)%3][k]) - (C+1)'(crd[i][k]);
        f_next[i][k] = (C+1)'(crd[3+(i+1)%3][k]) - (C+1)'(crd[3+i][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= 1'b0;
    else     vld <= in_vld;
    tv <= tv_next;
    e  <= e_next;
    f  <= f_next;
  end
endmodule
`default_nettype wire

[rtl/tpo_axes.sv]
// Stages 2-3: face normals, edge cross products, in-plane edge normals.
`default_nettype none
module tpo_axes #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_vld,
  input  wire logic signed [COORD_BITS:0]  tv_in [5][3],
  input  wire logic signed [COORD_BITS:0]  e [3][3],
  input  wire logic signed [COORD_BITS:0]  f [3][3],
  output logic                             vld,
  output logic signed [COORD_BITS:0]       tv [5][3],
  output logic signed [3*COORD_BITS+5:0]   ax [17][3]
);
  import tpo_pkg::*;
  localparam int C  = COORD_BITS;
  localparam int W1 = 2 * C + 3;
  localparam int W2 = 3 * C + 6;

  logic                 vld2;
  logic signed [C:0]    tv2 [5][3];
  logic signed [C:0]    e2 [3][3];
  logic signed [C:0]    f2 [3][3];
  logic signed [W1-1:0] a1 [11][3];
  logic signed [W1-1:0] a1_next [11][3];
  logic signed [W2-1:0] ax_next [17][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a1_next[0][k] = W1'(e[0][(k+1)%3]) * W1'(e[1][(k+2)%3])
                    - W1'(e[0][(k+2)%3]) * W1'(e[1][(k+1)%3]);
      a1_next[1][k] = W1'(f[0][(k+1)%3]) * W1'(f[1][(k+2)%3])
                    - W1'(f[0][(k+2)%3]) * W1'(f[1][(k+1)%3]);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          a1_next[2+3*i+j][k] = W1'(e[i][(k+1)%3]) * W1'(f[j][(k+2)%3])
                              - W1'(e[i][(k+2)%3]) * W1'(f[j][(k+1)%3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld2 <= 1'b0;
    else     vld2 <= in_vld;
    a1  <= a1_next;
    tv2 <= tv_in;
    e2  <= e;
    f2  <= f;
  end

  always_comb begin
    for (int x = 0; x < 11; x++)
      for (int k = 0; k < 3; k++) ax_next[x][k] = W2'(a1[x][k]);
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++) begin
        ax_next[11+i][k] = W2'(e2[i][(k+1)%3]) * W2'(a1[0][(k+2)%3])
                         - W2'(e2[i][(k+2)%3]) * W2'(a1[0][(k+1)%3]);
        ax_next[14+i][k] = W2'(f2[i][(k+1)%3]) * W2'(a1[1][(k+2)%3])
                         - W2'(f2[i][(k+2)%3]) * W2'(a1[1][(k+1)%3]);
      end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= 1'b0;
    else     vld <= vld2;
    ax <= ax_next;
    tv <= tv2;
  end
endmodule
`default_nettype wire

[rtl/tpo_project.sv]
// Stages 4-5: project vertices on every axis with split partial products.
`default_nettype none
module tpo_project #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_vld,
  input  wire logic signed [COORD_BITS:0]  tv [5][3],
  input  wire logic signed [3*COORD_BITS+5:0] ax [17][3],
  output logic                             vld,
  output logic signed [4*COORD_BITS+8:0]   proj [17][5]
);
  import tpo_pkg::*;
  localparam int C   = COORD_BITS;
  localparam int W2  = 3 * C + 6;
  localparam int LB  = (W2 + 1) / 2;
  localparam int HB  = W2 - LB;
  localparam int PLW = LB + C + 2;
  localparam int PHW = HB + C + 1;
  localparam int WP  = 4 * C + 9;

  logic                  vld4;
  logic signed [PLW-1:0] pl [17][5][3];
  logic signed [PHW-1:0] ph [17][5][3];
  logic signed [PLW-1:0] pl_next [17][5][3];
  logic signed [PHW-1:0] ph_next [17][5][3];
  logic signed [WP-1:0]  proj_next [17][5];

  always_comb begin
    for (int x = 0; x < 17; x++)
      for (int p = 0; p < 5; p++)
        for (int k = 0; k < 3; k++) begin
          pl_next[x][p][k] = PLW'($signed({1'b0, ax[x][k][LB-1:0]})) * PLW'(tv[p][k]);
          ph_next[x][p][k] = PHW'($signed(ax[x][k][W2-1:LB])) * PHW'(tv[p][k]);
        end
  end

  always_ff @(posedge clk) begin
    if (rst) vld4 <= 1'b0;
    else     vld4 <= in_vld;
    pl <= pl_next;
    ph <= ph_next;
  end

  always_comb begin
    for (int x = 0; x < 17; x++)
      for (int p = 0; p < 5; p++) begin
        proj_next[x][p] = '0;
        for (int k = 0; k < 3; k++)
          proj_next[x][p] = proj_next[x][p] + (WP'(ph[x][p][k]) <<< LB)
                          + WP'(pl[x][p][k]);
      end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= 1'b0;
    else     vld <= vld4;
    proj <= proj_next;
  end
endmodule
`default_nettype wire

[rtl/tpo_decide.sv]
// Stage 6: interval test on every axis and final overlap flag.
`default_nettype none
module tpo_decide #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_vld,
  input  wire logic signed [4*COORD_BITS+8:0] proj [17][5],
  output logic                             vld,
  output logic                             overlap
);
  import tpo_pkg::*;
  localparam int WP = 4 * COORD_BITS + 9;

  logic signed [WP-1:0] amin, amax, bmin, bmax;
  logic                 sep;

  always_comb begin
    sep = 1'b0;
    amin = '0; amax = '0; bmin = '0; bmax = '0;
    for (int x = 0; x < 17; x++) begin
      amin = '0;
      amax = '0;
      for (int p = 0; p < 2; p++) begin
        if (proj[x][p] < amin) amin = proj[x][p];
        if (proj[x][p] > amax) amax = proj[x][p];
      end
      bmin = proj[x][2];
      bmax = proj[x][2];
      for (int p = 3; p < 5; p++) begin
        if (proj[x][p] < bmin) bmin = proj[x][p];
        if (proj[x][p] > bmax) bmax = proj[x][p];
      end
      if (bmax < amin || amax < bmin) sep = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= 1'b0;
    else     vld <= in_vld;
    overlap <= ~sep;
  end
endmodule
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the triangle pair overlap separating axis pipeline.
module tb_top;
  import tpo_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  typedef logic signed [127:0] wint_t;
  typedef wint_t vec_t [3];

  class overlap_scoreboard;
    bit exp_q[$];
    int mismatches;
    int checked;
    int n_overlap;
    int n_disjoint;

    function void note_pair(bit exp_ovl);
      exp_q = {exp_q, exp_ovl};
    endfunction

    function void check_result(bit got);
      bit want;
      if (exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result overlap=%0b", got);
        return;
      end
      want = exp_q.pop_front();
      checked++;
      if (got) n_overlap++;
      else n_disjoint++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("overlap mismatch #%0d: expected %0b actual %0b", checked, want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [VERT_BITS-1:0] tri_a_v0 = '0, tri_a_v1 = '0, tri_a_v2 = '0;
  logic [VERT_BITS-1:0] tri_b_v0 = '0, tri_b_v1 = '0, tri_b_v2 = '0;
  logic busy, done, overlap;
  overlap_scoreboard sb;
  int sent;

  always #1 clk = ~clk;

  triangle_pair_overlap_sat dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .tri_a_v0(tri_a_v0), .tri_a_v1(tri_a_v1), .tri_a_v2(tri_a_v2),
    .tri_b_v0(tri_b_v0), .tri_b_v1(tri_b_v1), .tri_b_v2(tri_b_v2),
    .done(done), .overlap(overlap)
  );

  function automatic vec_t unpack_vert(logic [VERT_BITS-1:0] p);
    vec_t r;
    for (int k = 0; k < 3; k++) r[k] = wint_t'($signed(p[k*CB +: CB]));
    return r;
  endfunction

  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t r;
    for (int k = 0; k < 3; k++) r[k] = a[k] - b[k];
    return r;
  endfunction

  function automatic vec_t vcross(vec_t a, vec_t b);
    vec_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic wint_t vdot(vec_t a, vec_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic bit axis_splits(vec_t ax, vec_t a [3], vec_t b [3]);
    wint_t amin, amax, bmin, bmax, pa, pb;
    amin = vdot(ax, a[0]); amax = amin;
    bmin = vdot(ax, b[0]); bmax = bmin;
    for (int i = 1; i < 3; i++) begin
      pa = vdot(ax, a[i]);
      pb = vdot(ax, b[i]);
      if (pa < amin) amin = pa;
      if (pa > amax) amax = pa;
      if (pb < bmin) bmin = pb;
      if (pb > bmax) bmax = pb;
    end
    return (bmax < amin) || (amax < bmin);
  endfunction

  function automatic bit predict_overlap(logic [VERT_BITS-1:0] v [6]);
    vec_t a [3], b [3], e [3], f [3], ax [17];
    vec_t org, n, m;
    int c;
    bit split;
    c = 0;
    split = 0;
    org = unpack_vert(v[0]);
    for (int i = 0; i < 3; i++) begin
      a[i] = vsub(unpack_vert(v[i]), org);
      b[i] = vsub(unpack_vert(v[3+i]), org);
    end
    for (int i = 0; i < 3; i++) begin
      e[i] = vsub(a[(i+1)%3], a[i]);
      f[i] = vsub(b[(i+1)%3], b[i]);
    end
    n = vcross(e[0], e[1]);
    m = vcross(f[0], f[1]);
    ax[c++] = n;
    ax[c++] = m;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) ax[c++] = vcross(e[i], f[j]);
    for (int i = 0; i < 3; i++) ax[c++] = vcross(e[i], n);
    for (int i = 0; i < 3; i++) ax[c++] = vcross(f[i], m);
    for (int i = 0; i < 17; i++)
      if (axis_splits(ax[i], a, b)) split = 1;
    return !split;
  endfunction

  function automatic logic [VERT_BITS-1:0] pack_vert(int x, int y, int z);
    logic [VERT_BITS-1:0] r;
    r = '0;
    r[0 +: CB] = x[CB-1:0];
    r[CB +: CB] = y[CB-1:0];
    r[2*CB +: CB] = z[CB-1:0];
    return r;
  endfunction

  function automatic int rnd_coord(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  task automatic send_pair(logic [VERT_BITS-1:0] v [6]);
    tri_a_v0 <= v[0]; tri_a_v1 <= v[1]; tri_a_v2 <= v[2];
    tri_b_v0 <= v[3]; tri_b_v1 <= v[4]; tri_b_v2 <= v[5];
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_pair(predict_overlap(v));
    sent++;
    @(negedge clk);
  endtask

  task automatic pause_sender();
    start <= 0;
    repeat ($urandom_range(1, 5)) @(negedge clk);
  endtask

  always @(posedge clk)
    if (!rst && done) sb.check_result(overlap);

  initial begin
    #2000000;
    $display("[triangle_pair_overlap_sat] ERROR");
    $finish;
  end

  initial begin
    logic [VERT_BITS-1:0] v [6];
    int span, dx, dy, dz, burst, wait_cyc;
    int mx, mn;
    sb = new();
    sent = 0;
    mx = (1 << (CB - 1)) - 1;
    mn = -(1 << (CB - 1));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: zero, identical, touching, separated, degenerate, extremes
    for (int i = 0; i < 6; i++) v[i] = '0;
    send_pair(v);
    v[0] = pack_vert(0, 0, 0); v[1] = pack_vert(10, 0, 0); v[2] = pack_vert(0, 10, 0);
    v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
    send_pair(v);
    v[3] = pack_vert(10, 0, 0); v[4] = pack_vert(20, 0, 0); v[5] = pack_vert(10, 10, 0);
    send_pair(v);
    v[3] = pack_vert(11, 0, 0); v[4] = pack_vert(20, 0, 0); v[5] = pack_vert(11, 10, 0);
    send_pair(v);
    v[3] = pack_vert(2, 2, -5); v[4] = pack_vert(2, 2, 5); v[5] = pack_vert(3, 3, 5);
    send_pair(v);
    v[3] = pack_vert(2, 2, 1); v[4] = pack_vert(2, 2, 5); v[5] = pack_vert(3, 3, 5);
    send_pair(v);
    v[3] = pack_vert(1, 1, 1); v[4] = pack_vert(1, 1, 1); v[5] = pack_vert(1, 1, 1);
    send_pair(v);
    v[3] = pack_vert(1, 1, 0); v[4] = pack_vert(1, 1, 0); v[5] = pack_vert(1, 1, 0);
    send_pair(v);
    v[0] = pack_vert(mn, mn, mn); v[1] = pack_vert(mx, mx, mx); v[2] = pack_vert(mx, mn, mx);
    v[3] = pack_vert(mx, mn, mn); v[4] = pack_vert(mn, mx, mn); v[5] = pack_vert(mn, mn, mx);
    send_pair(v);
    v[0] = pack_vert(mx, mx, mx); v[1] = pack_vert(mn, mn, mn); v[2] = pack_vert(mn, mx, mn);
    v[3] = pack_vert(mn, mx, mx); v[4] = pack_vert(mx, mn, mx); v[5] = pack_vert(mx, mx, mn);
    send_pair(v);
    for (int i = 0; i < 6; i++) v[i] = {VERT_BITS{1'b1}};
    send_pair(v);
    for (int i = 0; i < 6; i++) v[i] = {{(VERT_BITS/2){2'b10}}};
    send_pair(v);
    for (int i = 0; i < 6; i++) v[i] = {{(VERT_BITS/2){2'b01}}};
    send_pair(v);
    pause_sender();

    // random: mostly nearby triangles so both outcomes show up, some full-range
    while (sent < 1650) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        case ($urandom_range(0, 3))
          0: for (int i = 0; i < 6; i++) v[i] = VERT_BITS'({$urandom, $urandom});
          1: begin
            span = 1 << $urandom_range(2, CB - 3);
            for (int i = 0; i < 6; i++)
              v[i] = pack_vert(rnd_coord(span), rnd_coord(span), rnd_coord(span));
          end
          default: begin
            span = 1 << $urandom_range(2, CB - 4);
            dx = rnd_coord(2 * span); dy = rnd_coord(2 * span); dz = rnd_coord(2 * span);
            for (int i = 0; i < 3; i++)
              v[i] = pack_vert(rnd_coord(span), rnd_coord(span), rnd_coord(span));
            for (int i = 3; i < 6; i++)
              v[i] = pack_vert(rnd_coord(span) + dx, rnd_coord(span) + dy,
                               rnd_coord(span) + dz);
            if ($urandom_range(0, 7) == 0) v[5] = v[4];
          end
        endcase
        send_pair(v);
      end
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
    start <= 0;

    wait_cyc = 0;
    while (sb.exp_q.size() != 0 && wait_cyc < 1000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    $display("Sent %0d triangle pairs, checked %0d results (%0d overlap, %0d disjoint).",
             sent, sb.checked, sb.n_overlap, sb.n_disjoint);
    $display("Mismatches: %0d, still pending: %0d", sb.mismatches, sb.exp_q.size());
    if (sb.mismatches == 0 && sb.exp_q.size() == 0)
      $display("[triangle_pair_overlap_sat] OK");
    else
      $display("[triangle_pair_overlap_sat] ERROR");
    $finish;
  end
endmodule

[sim.f]
rtl/tpo_pkg.sv
rtl/tpo_edges.sv
rtl/tpo_axes.sv
rtl/tpo_project.sv
rtl/tpo_decide.sv
rtl/triangle_pair_overlap_sat.sv
dv/tb_top.sv
